>>> rtl/bounded_ordered_list_store_core_assert.svh
// Assertion macros for the ordered list store core.
// No dependencies; included by the top level, which supplies clk_i and rst_ni.
`ifndef BOUNDED_ORDERED_LIST_STORE_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_STORE_CORE_ASSERT_SVH

// Implication checked on every edge outside reset.
`define BOLS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bols assertion failed");

// Next-cycle implication.
`define BOLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bols assertion failed");

// Condition that must never hold.
`define BOLS_ASSERT_NEVER(label, cond) \
  `BOLS_ASSERT_IMPL(label, 1'b1, !(cond))

`endif

>>> rtl/bols_pkg.sv
// Shared types and constants for the ordered list store core.
// No dependencies.
`default_nettype none

package bols_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CNT_OUT_W = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_APPEND     = 2'd1,
    REQ_DELETE     = 2'd2,
    REQ_READ       = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BEYOND    = 3'd4
  } status_e;

  typedef struct packed {
    logic cmp_en;
    logic push_front;
    logic append;
    logic del_shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/bols_cell.sv
// One storage cell of the list chain: holds an entry, compares, shifts, takes appends, serves reads.
// Depends on bols_pkg.
`default_nettype none

module bols_cell #(
  parameter int unsigned DEPTH    = bols_pkg::DEPTH_DEF,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic                                      clk_i,
  input  wire bols_pkg::cell_ctrl_t                      ctrl_i,
  input  wire logic [$clog2(DEPTH+1)-1:0]                count_i,
  input  wire logic [bols_pkg::DATA_W-1:0]               cmp_value_i,
  input  wire logic [bols_pkg::DATA_W-1:0]               wr_value_i,
  input  wire logic [bols_pkg::IDX_W-1:0]                rd_idx_i,
  input  wire logic [bols_pkg::DATA_W-1:0]               left_data_i,
  input  wire logic [bols_pkg::DATA_W-1:0]               right_data_i,
  input  wire logic                                      seen_i,
  input  wire logic [bols_pkg::DATA_W-1:0]               rd_i,
  output logic      [bols_pkg::DATA_W-1:0]               data_o,
  output logic                                           seen_o,
  output logic      [bols_pkg::DATA_W-1:0]               rd_o
);
  import bols_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
  localparam bit RD_REACH = (CELL_IDX < (1 << IDX_W));
  localparam logic [IDX_W-1:0] RD_POS = IDX_W'(CELL_IDX);

  logic [DATA_W-1:0] data_q, data_d;
  logic              match_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      match_q <= (data_q == cmp_value_i) && (MY_POS < count_i);
    end
    data_q <= data_d;
  end

  assign seen_o = seen_i | match_q;

  always_comb begin
    data_d = data_q;
    priority if (ctrl_i.push_front) begin
      data_d = left_data_i;
    end else if (ctrl_i.append) begin
      if (MY_POS == count_i) data_d = wr_value_i;
    end else if (ctrl_i.del_shift) begin
      if (seen_o) data_d = right_data_i;
    end
  end

  assign data_o = data_q;
  assign rd_o   = (RD_REACH && (rd_idx_i == RD_POS)) ? data_q : rd_i;

endmodule

`default_nettype wire

>>> rtl/bounded_ordered_list_store_core.sv
// Top level of the ordered list store: request capture, control, cell chain.
// Depends on bols_pkg, bols_cell and bounded_ordered_list_store_core_assert.svh.
`default_nettype none
//
// Usage
//   A request beat (req_type_i, value_i, index_i) is taken at a rising edge
//   with start high and busy low. Requests: push front, append at tail,
//   delete first match, read at index.
//   On the edge that takes a request every cell compares its entry with
//   value_i; the next cycle (busy high) the chain shifts, writes or reads.
//   The result beat (status_o, entry_count_o, read_value_o) follows in the
//   cycle after that, marked by done_o for exactly one cycle; it cannot be
//   held off. busy is low again in that cycle, so a new request can be
//   taken on the same edge that ends the result beat.
//   No new request is taken until the last one has shifted, since its
//   compare step lies in front of the shift step; the first-match search
//   ripples one bit through the cells. Reset clears the entry count and
//   control; entries are not cleared and are never read before being
//   written.

module bounded_ordered_list_store_core #(
  parameter int unsigned DEPTH = bols_pkg::DEPTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        req_type_i,
  input  wire logic signed [bols_pkg::DATA_W-1:0] value_i,
  input  wire logic [bols_pkg::IDX_W-1:0]        index_i,
  output logic                                   done_o,
  output logic [bols_pkg::STATUS_W-1:0]          status_o,
  output logic [bols_pkg::CNT_OUT_W-1:0]         entry_count_o,
  output logic signed [bols_pkg::DATA_W-1:0]     read_value_o
);
  import bols_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  req_e              req_q;
  logic [DATA_W-1:0] val_q;
  logic [IDX_W-1:0]  idx_q;
  logic              accept;
  logic              exec;
  logic              full, empty, found, beyond;
  status_e           status_d;
  logic [31:0]       cnt_ext;
  cell_ctrl_t        ctrl;

  logic [DATA_W-1:0] data_w [DEPTH];
  logic              seen_w [DEPTH+1];
  logic [DATA_W-1:0] rd_w   [DEPTH+1];

  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;
  assign exec   = (state_q == S_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_o  <= exec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_e'(req_type_i);
      val_q <= value_i;
      idx_q <= index_i;
    end
    if (exec) begin
      status_o      <= status_d;
      entry_count_o <= cnt_ext[CNT_OUT_W-1:0];
      read_value_o  <= (req_q == REQ_READ && !beyond) ? rd_w[DEPTH] : '0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (start) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign full   = (count_q == CNT_FULL);
  assign empty  = (count_q == '0);
  assign found  = seen_w[DEPTH];
  assign beyond = ({{(32-IDX_W){1'b0}}, idx_q} >= 32'(count_q));

  always_comb begin
    status_d = ST_OK;
    count_d  = count_q;
    unique case (req_q)
      REQ_PUSH_FRONT, REQ_APPEND: begin
        if (full) status_d = ST_FULL;
        else if (exec) count_d = count_q + CNT_ONE;
      end
      REQ_DELETE: begin
        if (empty) status_d = ST_EMPTY;
        else if (!found) status_d = ST_NOT_FOUND;
        else if (exec) count_d = count_q - CNT_ONE;
      end
      REQ_READ: begin
        if (beyond) status_d = ST_BEYOND;
      end
      default: status_d = ST_OK;
    endcase
  end

  assign cnt_ext = 32'(count_d);

  always_comb begin
    ctrl.cmp_en     = accept;
    ctrl.push_front = exec && (req_q == REQ_PUSH_FRONT) && !full;
    ctrl.append     = exec && (req_q == REQ_APPEND) && !full;
    ctrl.del_shift  = exec && (req_q == REQ_DELETE) && found;
  end

  assign seen_w[0] = 1'b0;
  assign rd_w[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_data;
    logic [DATA_W-1:0] right_data;
    if (i == 0) begin : g_head
      assign left_data = val_q;
    end else begin : g_body
      assign left_data = data_w[i-1];
    end
    if (i == DEPTH-1) begin : g_tail
      assign right_data = data_w[i];
    end else begin : g_inner
      assign right_data = data_w[i+1];
    end

    bols_cell #(
      .DEPTH    (DEPTH),
      .CELL_IDX (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .cmp_value_i  (value_i),
      .wr_value_i   (val_q),
      .rd_idx_i     (idx_q),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .seen_i       (seen_w[i]),
      .rd_i         (rd_w[i]),
      .data_o       (data_w[i]),
      .seen_o       (seen_w[i+1]),
      .rd_o         (rd_w[i+1])
    );
  end

  `include "bounded_ordered_list_store_core_assert.svh"

  `BOLS_ASSERT_NEVER(a_count_bound, count_q > CNT_FULL)
  `BOLS_ASSERT_NEXT(a_accept_busy, accept, busy && !done_o)
  `BOLS_ASSERT_NEXT(a_exec_done, exec, done_o && !busy)
  `BOLS_ASSERT_IMPL(a_full_status, done_o && status_o == ST_FULL, count_q == CNT_FULL)

endmodule

`default_nettype wire

>>> tb/sv/bols_list_checker.sv
// Watches request and result beats of the ordered list store core and checks each result
// against its own copy of the list. Depends on bols_pkg only.
`timescale 1ns / 1ps

module bols_list_checker #(
  parameter int unsigned DEPTH = bols_pkg::DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  input  logic                                  busy,
  input  logic [1:0]                            req_type_i,
  input  logic signed [bols_pkg::DATA_W-1:0]    value_i,
  input  logic [bols_pkg::IDX_W-1:0]            index_i,
  input  logic                                  done_o,
  input  logic [bols_pkg::STATUS_W-1:0]         status_o,
  input  logic [bols_pkg::CNT_OUT_W-1:0]        entry_count_o,
  input  logic signed [bols_pkg::DATA_W-1:0]    read_value_o,
  output int unsigned                           err_cnt_o,
  output int unsigned                           pending_o
);
  import bols_pkg::*;

  typedef struct packed {
    status_e                       status;
    logic [CNT_OUT_W-1:0]          count;
    logic signed [DATA_W-1:0]      rdata;
  } list_reply_t;

  logic signed [DATA_W-1:0] shadow_entries [DEPTH];
  int unsigned              shadow_count;
  list_reply_t              replies_due [$];
  int unsigned              err_cnt;

  function automatic list_reply_t apply_list_req(input req_e kind,
                                                 input logic signed [DATA_W-1:0] val,
                                                 input logic [IDX_W-1:0] ix);
    list_reply_t r;
    int unsigned hit;
    r.status = ST_OK;
    r.rdata  = '0;
    case (kind)
      REQ_PUSH_FRONT, REQ_APPEND: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (kind == REQ_PUSH_FRONT) begin
          for (int unsigned i = shadow_count; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = val;
          shadow_count++;
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
        end
      end
      REQ_DELETE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          hit = shadow_count;
          for (int unsigned i = 0; i < shadow_count; i++) begin
            if (hit == shadow_count && shadow_entries[i] == val) hit = i;
          end
          if (hit == shadow_count) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int unsigned i = hit; i + 1 < shadow_count; i++) begin
              shadow_entries[i] = shadow_entries[i+1];
            end
            shadow_count--;
          end
        end
      end
      default: begin
        if (ix >= shadow_count || ix >= DEPTH) r.status = ST_BEYOND;
        else r.rdata = shadow_entries[ix];
      end
    endcase
    r.count = shadow_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_reply_t want;
    if (!rst_ni) begin
      shadow_count = 0;
      replies_due.delete();
      err_cnt = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      // result beat first: it belongs to a request taken on an earlier edge
      if (done_o) begin
        if (replies_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("result beat with none outstanding: st=%0d cnt=%0d rd=%0d",
                                      status_o, entry_count_o, read_value_o);
        end else begin
          want = replies_due.pop_front();
          if (status_o !== want.status || entry_count_o !== want.count ||
              read_value_o !== want.rdata) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch: st exp %0d got %0d, cnt exp %0d got %0d, rd exp %0d got %0d",
                       want.status, status_o, want.count, entry_count_o, want.rdata,
                       read_value_o);
            end
          end
        end
      end
      if (start && !busy) begin
        replies_due.push_back(apply_list_req(req_e'(req_type_i), value_i, index_i));
      end
      err_cnt_o <= err_cnt;
      pending_o <= replies_due.size();
    end
  end

endmodule

>>> tb/sv/tb_bounded_ordered_list_store_core.sv
// Stimulus and verdict for the ordered list store core: directed requests, then random
// fill/drain/mixed runs. Depends on bols_pkg, the core and bols_list_checker.
`timescale 1ns / 1ps

module tb_bounded_ordered_list_store_core;
  import bols_pkg::*;

  localparam int unsigned N_RANDOM   = 550;
  localparam int unsigned CYCLE_LIMIT = 60000;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        start;
  logic                        busy;
  logic [1:0]                  req_type_i;
  logic signed [DATA_W-1:0]    value_i;
  logic [IDX_W-1:0]            index_i;
  logic                        done_o;
  logic [STATUS_W-1:0]         status_o;
  logic [CNT_OUT_W-1:0]        entry_count_o;
  logic signed [DATA_W-1:0]    read_value_o;
  int unsigned                 err_cnt;
  int unsigned                 pending;
  int unsigned                 cycle_cnt = 0;
  logic [DATA_W-1:0]           value_pool [6];

  always #5 clk_i = ~clk_i;

  bounded_ordered_list_store_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .read_value_o  (read_value_o)
  );

  bols_list_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .read_value_o  (read_value_o),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("bounded_ordered_list_store_core regression: fail");
      $finish;
    end
  end

  // returns on the edge that takes the request beat
  task automatic issue(input req_e kind, input logic [DATA_W-1:0] val,
                       input logic [IDX_W-1:0] ix);
    start      <= 1'b1;
    req_type_i <= kind;
    value_i    <= val;
    index_i    <= ix;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] pick_value(input int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  initial begin
    int unsigned n;
    int unsigned seg_len;
    int unsigned mode;
    int unsigned roll;
    int unsigned guard;
    req_e        kind;

    rst_ni     = 1'b0;
    start      = 1'b0;
    req_type_i = REQ_READ;
    value_i    = '0;
    index_i    = '0;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hffff_ffff;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7fff_ffff;
    value_pool[4] = $urandom;
    value_pool[5] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cases, extremes, duplicates, first match
    issue(REQ_READ,       32'h0,         4'd0);
    issue(REQ_READ,       32'h0,         4'd15);
    issue(REQ_DELETE,     32'h8000_0000, 4'd0);
    issue(REQ_PUSH_FRONT, 32'h8000_0000, 4'd0);
    issue(REQ_APPEND,     32'h7fff_ffff, 4'd15);
    issue(REQ_PUSH_FRONT, 32'hffff_ffff, 4'd0);
    issue(REQ_APPEND,     32'h0,         4'd0);
    issue(REQ_READ,       32'h0,         4'd0);
    issue(REQ_READ,       32'hffff_ffff, 4'd3);
    issue(REQ_READ,       32'h0,         4'd4);
    issue(REQ_DELETE,     32'h0000_0005, 4'd0);
    issue(REQ_DELETE,     32'h7fff_ffff, 4'd0);
    issue(REQ_DELETE,     32'hffff_ffff, 4'd0);
    issue(REQ_APPEND,     32'h0,         4'd0);
    issue(REQ_PUSH_FRONT, 32'h0,         4'd0);
    issue(REQ_DELETE,     32'h0,         4'd0);
    issue(REQ_READ,       32'h0,         4'd1);
    issue(REQ_READ,       32'h0,         4'd2);
    issue(REQ_DELETE,     32'h8000_0000, 4'd0);
    issue(REQ_DELETE,     32'h0,         4'd0);
    issue(REQ_DELETE,     32'h0,         4'd0);

    // random: mode 0 fills, 1 drains, 2 mixed; the first run always fills
    n = 0;
    mode = 0;
    while (n < N_RANDOM) begin
      seg_len = $urandom_range(15, 40);
      for (int unsigned k = 0; k < seg_len && n < N_RANDOM; k++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       kind = (roll < 40) ? REQ_PUSH_FRONT : (roll < 78) ? REQ_APPEND :
                          (roll < 86) ? REQ_DELETE : REQ_READ;
          1:       kind = (roll < 65) ? REQ_DELETE : (roll < 72) ? REQ_PUSH_FRONT :
                          (roll < 78) ? REQ_APPEND : REQ_READ;
          default: kind = req_e'($urandom_range(0, 3));
        endcase
        if (n == 300) begin
          // hold off until the store has answered everything
          start <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end else if ((n < 150 || n > 250) && $urandom_range(0, 99) < 31) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
        issue(kind, pick_value((kind == REQ_DELETE) ? 85 : 50), 4'($urandom_range(0, 15)));
        n++;
      end
      mode = $urandom_range(0, 2);
    end

    start <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (pending != 0 && guard < 200) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("bounded_ordered_list_store_core regression: pass");
    end else begin
      $display("bounded_ordered_list_store_core regression: fail");
    end
    $finish;
  end

endmodule
